/* hdl/dblur_pkg.sv */
// Package for the directional 3x3 blur: shared types, kernel constants and
// the tap-weight helpers used by the blur lanes and the top level.
// No dependencies.
package dblur_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HORIZ_SIDE   = 2'd2;
    localparam logic [1:0] REG_VERT_SIDE    = 2'd3;

    // Side selector codes (code 3 raises nothing)
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_FIRST = 2'd1;  // left column / row above
    localparam logic [1:0] SIDE_LAST  = 2'd2;  // right column / row below

    // Kernel sums for zero, one and two raised sides
    localparam int KSUM_PLAIN = 767;
    localparam int KSUM_ONE   = 959;
    localparam int KSUM_TWO   = 1087;

    // Reciprocals for the divide-by-kernel-sum, floor(2^RECIP_SHIFT / sum)
    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_PLAIN = 19'((64'd1 << RECIP_SHIFT) / KSUM_PLAIN);
    localparam logic [18:0] RECIP_ONE   = 19'((64'd1 << RECIP_SHIFT) / KSUM_ONE);
    localparam logic [18:0] RECIP_TWO   = 19'((64'd1 << RECIP_SHIFT) / KSUM_TWO);

    // Output queue geometry
    localparam int OQ_DEPTH = 16;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // 3x3 window, index row*3+col, rows top..bottom, columns left..right
    typedef logic [8:0][7:0] win_t;

    // Control that travels with one window through a blur lane
    typedef struct packed {
        logic valid;
        logic frame_end;
    } lane_ctl_t;

    // Item held between acceptance and the line store write-back
    typedef struct packed {
        logic [7:0] cur;
        logic       r_ge1;
        logic       r_ge2;
        logic       c_ge1;
        logic       c_ge2;
        logic       last;
        logic       flush;
    } item_t;

    // Output queue entry
    typedef struct packed {
        logic       frame_end;
        logic [7:0] blurred;
    } oq_entry_t;

    function automatic logic side_on(input logic [1:0] side);
        return (side == SIDE_FIRST) || (side == SIDE_LAST);
    endfunction

    // Weighted contribution of one tap: 255 at the center, 128 on a raised
    // side, 64 elsewhere
    function automatic logic [18:0] tap_term(input logic [7:0] p,
                                             input logic [1:0] row,
                                             input logic [1:0] col,
                                             input logic [1:0] hs,
                                             input logic [1:0] vs);
        logic raised;
        raised = ((hs == SIDE_FIRST) && (col == 2'd0)) ||
                 ((hs == SIDE_LAST)  && (col == 2'd2)) ||
                 ((vs == SIDE_FIRST) && (row == 2'd0)) ||
                 ((vs == SIDE_LAST)  && (row == 2'd2));
        if ((row == 2'd1) && (col == 2'd1))
            return (19'(p) << 8) - 19'(p);
        else if (raised)
            return 19'(p) << 7;
        else
            return 19'(p) << 6;
    endfunction

    function automatic logic [10:0] kernel_sum(input logic [1:0] hs,
                                               input logic [1:0] vs);
        logic h_on;
        logic v_on;
        h_on = side_on(hs);
        v_on = side_on(vs);
        if (h_on && v_on)
            return 11'(KSUM_TWO);
        else if (h_on || v_on)
            return 11'(KSUM_ONE);
        else
            return 11'(KSUM_PLAIN);
    endfunction

    function automatic logic [18:0] kernel_recip(input logic [1:0] hs,
                                                 input logic [1:0] vs);
        logic h_on;
        logic v_on;
        h_on = side_on(hs);
        v_on = side_on(vs);
        if (h_on && v_on)
            return RECIP_TWO;
        else if (h_on || v_on)
            return RECIP_ONE;
        else
            return RECIP_PLAIN;
    endfunction

endpackage

/* hdl/dblur_lane.sv */
// One blur lane: weighted 3x3 sum, reciprocal multiply and one-step
// correction to divide by the kernel sum, then saturation. Three stages.
// Depends on dblur_pkg.
module dblur_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dblur_pkg::lane_ctl_t  ctl_in,
    input  dblur_pkg::win_t       win,
    input  logic [1:0]            hside,
    input  logic [1:0]            vside,
    output dblur_pkg::lane_ctl_t  ctl_out,
    output logic [7:0]            blurred
);

    dblur_pkg::lane_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic [18:0] acc_next;
    logic [18:0] acc1_reg, acc2_reg;
    logic [10:0] d1_reg, d2_reg;
    logic [18:0] m1_reg;
    logic [37:0] prod_next;
    logic [37:0] prod2_reg;
    logic [9:0]  q0;
    logic [20:0] qd;
    logic [20:0] rem;
    logic [10:0] qc;
    logic [7:0]  q_next;
    logic [7:0]  q3_reg;

    // Sum the nine weighted taps
    always_comb
    begin
        acc_next = '0;
        for (int tr = 0; tr < 3; tr++)
        begin
            for (int tc = 0; tc < 3; tc++)
            begin
                acc_next = acc_next + dblur_pkg::tap_term(win[tr * 3 + tc], 2'(tr),
                                                          2'(tc), hside, vside);
            end
        end
    end

    // Multiply by the reciprocal of the kernel sum
    assign prod_next = acc1_reg * m1_reg;

    // Estimate is at most one short: correct with one compare
    assign q0  = prod2_reg[dblur_pkg::RECIP_SHIFT +: 10];
    assign qd  = q0 * d2_reg;
    assign rem = {2'b00, acc2_reg} - qd;
    assign qc  = (rem >= {10'd0, d2_reg}) ? ({1'b0, q0} + 11'd1) : {1'b0, q0};
    assign q_next = (qc > 11'd255) ? 8'hFF : qc[7:0];

    // Advance the control every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Hold the datapath values alongside
    always_ff @(posedge clk)
    begin
        acc1_reg  <= acc_next;
        d1_reg    <= dblur_pkg::kernel_sum(hside, vside);
        m1_reg    <= dblur_pkg::kernel_recip(hside, vside);
        prod2_reg <= prod_next;
        acc2_reg  <= acc1_reg;
        d2_reg    <= d1_reg;
        q3_reg    <= q_next;
    end

    assign ctl_out = ctl3_reg;
    assign blurred = q3_reg;

endmodule

/* hdl/directional_3x3_blur_unit.sv */
// Directional 3x3 blur: top level with line store, window columns, two blur
// lanes and the output queue. Depends on dblur_pkg and dblur_lane.
//
// Usage: pixels enter on the s_ channel in raster order (s_tuser = 1 marks
// a flush item), blurred pixels leave on the m_ channel, m_tlast on the last
// pixel of a frame. After each frame send one row of frame_width flush items
// to push out the bottom row. Geometry and weight sides are written on the
// cfg_ port while the block is idle.
// Path: after the transaction that completes its window, a result passes the
// item stage, the window registers, the lane stages and the output queue.
// Output lags the input by one row and one column. Throughput: one pixel per
// cycle while s_tready is high; the first pixel of a row makes no result and
// the last makes two, so the output side keeps pace at one result per cycle
// while m_tready is high. Reset: the line store (one entry per column, both
// rows in one word) is swept to zero after reset, s_tready low meanwhile.
// Stall: results collect in a 16-entry queue; s_tready drops while the queue
// could not take the results of another transaction.
module directional_3x3_blur_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] command (1 = flush item)
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] blurred
    output logic        m_tlast,   // frame_end
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > 11) ? CW + 1 : 11;

    // Configuration registers
    logic [10:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    logic [1:0]  hside_reg;
    logic [1:0]  vside_reg;

    // Position counters
    logic [CW-1:0] column_count_reg;
    logic [15:0]   row_count_reg;

    // Clearing sweep
    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    // Line store: [15:8] upper row, [7:0] middle row
    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] rd_data_reg;

    // Item stage between read and write-back
    logic                s0_valid_reg;
    dblur_pkg::item_t    s0_reg;
    dblur_pkg::item_t    s0_next;
    logic [CW-1:0]       s0_col_reg;

    // Window columns: [0..2] older column, [3..5] newer column (top, mid, bottom)
    logic [7:0] wc_reg [6];

    // Window registers feeding the lanes
    dblur_pkg::lane_ctl_t ctl_a_next, ctl_b_next, ctl_a_reg, ctl_b_reg;
    dblur_pkg::win_t      win_a_next, win_b_next, win_a_reg, win_b_reg;
    dblur_pkg::lane_ctl_t out_a, out_b;
    logic [7:0]           blur_a, blur_b;

    // Output queue
    dblur_pkg::oq_entry_t          oq_mem [dblur_pkg::OQ_DEPTH];
    logic [dblur_pkg::OQ_PW-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_b;
    logic [dblur_pkg::OQ_CW-1:0]   oq_cnt_reg, oq_cnt_next;
    logic [dblur_pkg::OQ_CW-1:0]   used_reg, used_next;

    logic          s_accept;
    logic          m_accept;
    logic [XW-1:0] fw_ext;
    logic [XW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [1:0]    n_acc;
    logic [7:0]    top, mid, bot;

    // Clamp the geometry
    always_comb
    begin
        fw_ext = XW'(frame_width_reg);
        if (fw_ext < XW'(2))
            w_eff = XW'(2);
        else if (fw_ext > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        h_eff = (frame_height_reg == 16'd0) ? 16'd1 : frame_height_reg;
    end

    assign s_tready = !clr_active_reg &&
                      (used_reg <= dblur_pkg::OQ_CW'(dblur_pkg::OQ_DEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Classify the arriving item against the counters
    always_comb
    begin
        s0_next.flush = row_count_reg >= h_eff;
        s0_next.cur   = (s0_next.flush || s_tuser) ? 8'd0 : s_tdata;
        s0_next.last  = XW'(column_count_reg) >= (w_eff - XW'(1));
        s0_next.r_ge1 = row_count_reg != 16'd0;
        s0_next.r_ge2 = row_count_reg[15:1] != 15'd0;
        s0_next.c_ge1 = column_count_reg != '0;
        s0_next.c_ge2 = column_count_reg[CW-1:1] != '0;
        n_acc = 2'(s0_next.r_ge1 && s0_next.c_ge1) + 2'(s0_next.r_ge1 && s0_next.last);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 16'd1024;
            hside_reg        <= dblur_pkg::SIDE_FIRST;
            vside_reg        <= dblur_pkg::SIDE_LAST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dblur_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                dblur_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                dblur_pkg::REG_HORIZ_SIDE:   hside_reg        <= cfg_data[1:0];
                dblur_pkg::REG_VERT_SIDE:    vside_reg        <= cfg_data[1:0];
            endcase
        end
    end

    // Advance counters, clearing sweep and item stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            s0_valid_reg     <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                    clr_active_reg <= 1'b0;
                clr_addr_reg <= clr_addr_reg + CW'(1);
            end
            s0_valid_reg <= s_accept;
            if (s_accept)
            begin
                if (s0_next.last)
                begin
                    column_count_reg <= '0;
                    row_count_reg    <= s0_next.flush ? 16'd0 : row_count_reg + 16'd1;
                end
                else
                begin
                    column_count_reg <= column_count_reg + CW'(1);
                end
            end
        end
    end

    // Hold the item payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s0_reg     <= s0_next;
            s0_col_reg <= column_count_reg;
        end
    end

    // Line store: read at acceptance, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (s_accept)
            rd_data_reg <= line_mem[column_count_reg];
        if (clr_active_reg)
            line_mem[clr_addr_reg] <= 16'd0;
        else if (s0_valid_reg)
            line_mem[s0_col_reg] <= {rd_data_reg[7:0], s0_reg.cur};
    end

    // Mask rows not yet filled in this frame
    assign top = s0_reg.r_ge2 ? rd_data_reg[15:8] : 8'd0;
    assign mid = s0_reg.r_ge1 ? rd_data_reg[7:0]  : 8'd0;
    assign bot = s0_reg.cur;

    // Form the two windows
    always_comb
    begin
        win_a_next[0] = s0_reg.c_ge2 ? wc_reg[0] : 8'd0;
        win_a_next[3] = s0_reg.c_ge2 ? wc_reg[1] : 8'd0;
        win_a_next[6] = s0_reg.c_ge2 ? wc_reg[2] : 8'd0;
        win_a_next[1] = wc_reg[3];
        win_a_next[4] = wc_reg[4];
        win_a_next[7] = wc_reg[5];
        win_a_next[2] = top;
        win_a_next[5] = mid;
        win_a_next[8] = bot;

        win_b_next[0] = s0_reg.c_ge1 ? wc_reg[3] : 8'd0;
        win_b_next[3] = s0_reg.c_ge1 ? wc_reg[4] : 8'd0;
        win_b_next[6] = s0_reg.c_ge1 ? wc_reg[5] : 8'd0;
        win_b_next[1] = top;
        win_b_next[4] = mid;
        win_b_next[7] = bot;
        win_b_next[2] = 8'd0;
        win_b_next[5] = 8'd0;
        win_b_next[8] = 8'd0;

        ctl_a_next.valid     = s0_valid_reg && s0_reg.r_ge1 && s0_reg.c_ge1;
        ctl_a_next.frame_end = 1'b0;
        ctl_b_next.valid     = s0_valid_reg && s0_reg.r_ge1 && s0_reg.last;
        ctl_b_next.frame_end = s0_reg.flush;
    end

    // Shift the window columns and register the lane inputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                wc_reg[i] <= 8'd0;
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_b_next;
            if (s0_valid_reg)
            begin
                wc_reg[0] <= wc_reg[3];
                wc_reg[1] <= wc_reg[4];
                wc_reg[2] <= wc_reg[5];
                wc_reg[3] <= top;
                wc_reg[4] <= mid;
                wc_reg[5] <= bot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_a_reg <= win_a_next;
        win_b_reg <= win_b_next;
    end

    dblur_lane u_lane_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_a_reg),
        .win     (win_a_reg),
        .hside   (hside_reg),
        .vside   (vside_reg),
        .ctl_out (out_a),
        .blurred (blur_a)
    );

    dblur_lane u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_b_reg),
        .win     (win_b_reg),
        .hside   (hside_reg),
        .vside   (vside_reg),
        .ctl_out (out_b),
        .blurred (blur_b)
    );

    // Output queue: lane A result goes first, lane B right after it
    assign wr_ptr_b = wr_ptr_reg + dblur_pkg::OQ_PW'(out_a.valid);
    assign oq_cnt_next = oq_cnt_reg + dblur_pkg::OQ_CW'(out_a.valid)
                         + dblur_pkg::OQ_CW'(out_b.valid) - dblur_pkg::OQ_CW'(m_accept);
    assign used_next = used_reg + dblur_pkg::OQ_CW'(s_accept ? n_acc : 2'd0)
                       - dblur_pkg::OQ_CW'(m_accept);

    always_ff @(posedge clk)
    begin
        if (out_a.valid)
            oq_mem[wr_ptr_reg] <= '{frame_end: out_a.frame_end, blurred: blur_a};
        if (out_b.valid)
            oq_mem[wr_ptr_b] <= '{frame_end: out_b.frame_end, blurred: blur_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            oq_cnt_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_b + dblur_pkg::OQ_PW'(out_b.valid);
            if (m_accept)
                rd_ptr_reg <= rd_ptr_reg + dblur_pkg::OQ_PW'(1);
            oq_cnt_reg <= oq_cnt_next;
            used_reg   <= used_next;
        end
    end

    assign m_tvalid = oq_cnt_reg != '0;
    assign m_tdata  = oq_mem[rd_ptr_reg].blurred;
    assign m_tlast  = oq_mem[rd_ptr_reg].frame_end;

    // Write-back never targets the entry being read in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && s_accept) |-> (s0_col_reg != column_count_reg))
        else $error("line store read and write hit the same column");

    // Reserved results never exceed the queue
    a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= dblur_pkg::OQ_CW'(dblur_pkg::OQ_DEPTH))
        else $error("output reservation exceeds queue depth");

    // Queued results are always covered by a reservation
    a_queue_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= used_reg)
        else $error("output queue holds unreserved results");

    // No item is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("input accepted while line store is clearing");

    // The row-end result only comes with the in-row result
    a_lane_pairing: assert property (@(posedge clk) disable iff (!rst_n)
        out_b.valid |-> out_a.valid)
        else $error("row-end result without in-row result");

endmodule

/* sim/directional_3x3_blur_unit_test.sv */
// Self-checking regression for the directional 3x3 blur unit: random and
// directed pixel streams, an in-bench window predictor and a result scoreboard.
// Depends on dblur_pkg and directional_3x3_blur_unit.
`timescale 1ns / 100ps

module directional_3x3_blur_unit_test;

    localparam int          LINE_MAX        = 1024;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          WATCHDOG_LIMIT  = 10000;
    localparam int          RANDOM_ITEMS    = 320;
    localparam logic [1:0]  SIDE_UNUSED     = 2'd3;
    localparam logic        CMD_PIXEL       = 1'b0;
    localparam logic        CMD_FLUSH       = 1'b1;

    typedef struct {
        logic [7:0] blurred;
        logic       frame_end;
    } blur_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] pixel
    logic        s_tuser = 1'b0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] blurred
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // Predictor copy of the registers and the window state
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  hside_reg;
    logic [1:0]  vside_reg;
    logic [7:0]  upper_row [LINE_MAX];
    logic [7:0]  middle_row [LINE_MAX];
    logic [7:0]  win_cols [6];
    int unsigned col_pos;
    int unsigned row_pos;

    blur_result_t due_pixels [$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    directional_3x3_blur_unit #(
        .MAX_WIDTH(LINE_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned active_width();
        if (width_reg < 11'd2)
            return 2;
        if (width_reg > 11'(LINE_MAX))
            return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 16'd0)
            return 1;
        return height_reg;
    endfunction

    // Weighted mean of a 3x3 window, index row*3+col, truncated and clamped
    function automatic logic [7:0] weighted_mean(input dblur_pkg::win_t taps);
        int unsigned wt;
        int unsigned wsum;
        int unsigned acc;
        int unsigned q;
        int          r;
        int          c;
        wsum = 0;
        acc = 0;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                if (r == 1 && c == 1)
                    wt = 255;
                else if ((hside_reg == dblur_pkg::SIDE_FIRST && c == 0) ||
                         (hside_reg == dblur_pkg::SIDE_LAST && c == 2) ||
                         (vside_reg == dblur_pkg::SIDE_FIRST && r == 0) ||
                         (vside_reg == dblur_pkg::SIDE_LAST && r == 2))
                    wt = 128;
                else
                    wt = 64;
                wsum += wt;
                acc += wt * taps[r * 3 + c];
            end
        end
        q = acc / wsum;
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    task automatic clear_window_state();
        int i;
        width_reg = 11'd1024;
        height_reg = 16'd1024;
        hside_reg = dblur_pkg::SIDE_FIRST;
        vside_reg = dblur_pkg::SIDE_LAST;
        for (i = 0; i < LINE_MAX; i++)
        begin
            upper_row[i] = 8'd0;
            middle_row[i] = 8'd0;
        end
        for (i = 0; i < 6; i++)
            win_cols[i] = 8'd0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // Advance the window by one pixel and queue the blurred pixels it completes
    task automatic advance_window(input logic cmd, input logic [7:0] pix);
        int unsigned      w;
        int unsigned      h;
        logic             flush_row;
        logic             row_end;
        logic [7:0]       cur;
        logic [7:0]       above;
        logic [7:0]       center;
        dblur_pkg::win_t  taps;
        blur_result_t     res;
        w = active_width();
        h = active_height();
        flush_row = (row_pos >= h);
        cur = (flush_row || cmd == CMD_FLUSH) ? 8'd0 : pix;
        row_end = (col_pos >= w - 1);
        above = 8'd0;
        center = 8'd0;
        if (col_pos < LINE_MAX)
        begin
            above = upper_row[col_pos];
            center = middle_row[col_pos];
            upper_row[col_pos] = center;
            middle_row[col_pos] = cur;
        end
        // mask rows not yet filled in this frame
        if (row_pos < 2)
            above = 8'd0;
        if (row_pos < 1)
            center = 8'd0;

        // window centered one column back
        if (row_pos >= 1 && col_pos >= 1)
        begin
            taps = '0;
            if (col_pos >= 2)
            begin
                taps[0] = win_cols[0];
                taps[3] = win_cols[1];
                taps[6] = win_cols[2];
            end
            taps[1] = win_cols[3];
            taps[4] = win_cols[4];
            taps[7] = win_cols[5];
            taps[2] = above;
            taps[5] = center;
            taps[8] = cur;
            res.blurred = weighted_mean(taps);
            res.frame_end = 1'b0;
            due_pixels.push_back(res);
        end

        // window centered on the last column, right neighbors zero
        if (row_pos >= 1 && row_end)
        begin
            taps = '0;
            if (col_pos >= 1)
            begin
                taps[0] = win_cols[3];
                taps[3] = win_cols[4];
                taps[6] = win_cols[5];
            end
            taps[1] = above;
            taps[4] = center;
            taps[7] = cur;
            res.blurred = weighted_mean(taps);
            res.frame_end = flush_row;
            due_pixels.push_back(res);
        end

        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = above;
        win_cols[4] = center;
        win_cols[5] = cur;

        if (row_end)
        begin
            col_pos = 0;
            row_pos = flush_row ? 0 : ((row_pos + 1) & 32'hFFFF);
        end
        else
            col_pos = col_pos + 1;
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dblur_pkg::REG_FRAME_WIDTH:  width_reg = val[10:0];
            dblur_pkg::REG_FRAME_HEIGHT: height_reg = val;
            dblur_pkg::REG_HORIZ_SIDE:   hside_reg = val[1:0];
            default:                     vside_reg = val[1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                                input logic [1:0] hs, input logic [1:0] vs);
        write_reg(dblur_pkg::REG_FRAME_WIDTH, w);
        write_reg(dblur_pkg::REG_FRAME_HEIGHT, h);
        write_reg(dblur_pkg::REG_HORIZ_SIDE, {14'd0, hs});
        write_reg(dblur_pkg::REG_VERT_SIDE, {14'd0, vs});
    endtask

    // Send one pixel transaction in bursts separated by random gaps
    task automatic send_pixel(input logic cmd, input logic [7:0] pix);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        advance_window(cmd, pix);
        items_sent++;
    endtask

    // Drain all pending results, then give the pipeline time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send random pixels until the frame closes, flush row included
    task automatic run_to_frame_end();
        logic       cmd;
        logic [7:0] pix;
        do
        begin
            pix = 8'($urandom_range(0, 255));
            if (row_pos >= active_height())
                cmd = 1'($urandom_range(0, 1));
            else
                cmd = ($urandom_range(0, 15) == 0) ? CMD_FLUSH : CMD_PIXEL;
            send_pixel(cmd, pix);
        end
        while (row_pos != 0 || col_pos != 0);
    endtask

    // Extreme pixels, a flush command inside the frame, junk in the flush row
    task automatic test_edge_pixels();
        set_geometry(16'd2, 16'd2, dblur_pkg::SIDE_FIRST, dblur_pkg::SIDE_LAST);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_PIXEL, 8'd0);
        send_pixel(CMD_FLUSH, 8'd255);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_FLUSH, 8'd0);
        settle();
    endtask

    // Width below two and height zero, with unusual side codes
    task automatic test_small_geometry();
        set_geometry(16'd0, 16'd0, dblur_pkg::SIDE_NONE, SIDE_UNUSED);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_PIXEL, 8'd128);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_FLUSH, 8'd255);
        settle();
        set_geometry(16'd1, 16'd1, SIDE_UNUSED, dblur_pkg::SIDE_FIRST);
        send_pixel(CMD_PIXEL, 8'd0);
        send_pixel(CMD_PIXEL, 8'd255);
        send_pixel(CMD_FLUSH, 8'd0);
        send_pixel(CMD_PIXEL, 8'd0);
        settle();
    endtask

    // Shrink height and width while a frame is open
    task automatic test_mid_frame_resize();
        int i;
        set_geometry(16'd2, 16'd65535, dblur_pkg::SIDE_FIRST, dblur_pkg::SIDE_FIRST);
        for (i = 0; i < 4; i++)
            send_pixel(CMD_PIXEL, 8'($urandom_range(0, 255)));
        settle();
        write_reg(dblur_pkg::REG_FRAME_HEIGHT, 16'd1);
        run_to_frame_end();
        settle();
        set_geometry(16'd4, 16'd1, dblur_pkg::SIDE_LAST, dblur_pkg::SIDE_NONE);
        for (i = 0; i < 3; i++)
            send_pixel(CMD_PIXEL, 8'($urandom_range(0, 255)));
        settle();
        write_reg(dblur_pkg::REG_FRAME_WIDTH, 16'd2);
        run_to_frame_end();
        settle();
    endtask

    // Every pair of side codes on small frames
    task automatic test_side_sweep();
        int hs;
        int vs;
        for (hs = 0; hs < 4; hs++)
        begin
            for (vs = 0; vs < 4; vs++)
            begin
                set_geometry(16'($urandom_range(2, 8)), 16'($urandom_range(1, 4)),
                             2'(hs), 2'(vs));
                run_to_frame_end();
                settle();
            end
        end
    endtask

    // One full row at a width past the line store, then a narrow row reads it back
    task automatic test_wide_rows();
        int i;
        set_geometry(16'd2047, 16'd1, dblur_pkg::SIDE_FIRST, dblur_pkg::SIDE_NONE);
        for (i = 0; i < LINE_MAX; i++)
            send_pixel(CMD_PIXEL, 8'($urandom_range(0, 255)));
        settle();
        write_reg(dblur_pkg::REG_FRAME_WIDTH, 16'd3);
        run_to_frame_end();
        settle();
    endtask

    // Random geometry per frame, some frames resized while open
    task automatic test_random_frames();
        int unsigned start;
        int unsigned w;
        int unsigned h;
        int unsigned part;
        int unsigned i;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       w = $urandom_range(0, 1);
                1, 2, 3: w = $urandom_range(13, 64);
                default: w = $urandom_range(2, 12);
            endcase
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            set_geometry(16'(w), 16'(h), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0)
            begin
                part = $urandom_range(1, active_width() * (active_height() + 1) - 1);
                for (i = 0; i < part; i++)
                    send_pixel(CMD_PIXEL, 8'($urandom_range(0, 255)));
                settle();
                if ($urandom_range(0, 1) == 0)
                    write_reg(dblur_pkg::REG_FRAME_WIDTH, 16'($urandom_range(2, 12)));
                else
                    write_reg(dblur_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(0, 6)));
            end
            run_to_frame_end();
            settle();
        end
    endtask

    // Stimulus sequence
    initial
    begin
        clear_window_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the line store sweep has finished
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        test_edge_pixels();
        test_small_geometry();
        test_mid_frame_resize();
        test_side_sweep();
        test_wide_rows();
        test_random_frames();
        settle();
        $display("Covered %0d pixel transactions, %0d blurred pixels checked, %0d frames closed",
                 items_sent, results_checked, frames_seen);
        if (mismatches == 0)
            $display("directional_3x3_blur_unit regression: pass");
        else
            $display("directional_3x3_blur_unit regression: fail");
        $finish;
    end

    // Drive the output ready on a changing stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((stall_left % 32) < 8);
        endcase
    end

    // Compare each result transaction with the oldest expected pixel
    always @(posedge clk)
    begin : result_check
        blur_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result blurred=%0d frame_end=%0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = due_pixels.pop_front();
                results_checked++;
                if (m_tlast)
                    frames_seen++;
                if (m_tdata !== want.blurred)
                begin
                    mismatches++;
                    $display("%0t: blurred expected %0d actual %0d",
                             $time, want.blurred, m_tdata);
                end
                if (m_tlast !== want.frame_end)
                begin
                    mismatches++;
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, want.frame_end, m_tlast);
                end
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("directional_3x3_blur_unit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

/* directional_3x3_blur_unit.f */
hdl/dblur_pkg.sv
hdl/dblur_lane.sv
hdl/directional_3x3_blur_unit.sv
sim/directional_3x3_blur_unit_test.sv
